[src/morton_order_point_sorter_core_defines.svh]
// Assertion macros used by the checker file of the point sorter.
`ifndef MORTON_ORDER_POINT_SORTER_CORE_DEFINES_SVH
`define MORTON_ORDER_POINT_SORTER_CORE_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define MOPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be seen outside reset.
`define MOPS_NEVER(lbl, cond, msg) \
  `MOPS_ASSERT(lbl, !(cond), msg)

`endif

[src/mops_pkg.sv]
package mops_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MaxBoxesDef  = 64;
  localparam int unsigned DimsDef      = 3;
  localparam int unsigned CoordBitsDef = 16;

  // Fixed port widths.
  localparam int unsigned InBits  = 16;
  localparam int unsigned IdxBits = 6;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StEmit = 3'b100
  } state_e;

endpackage

[src/mops_ram.sv]
module mops_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[src/mops_cmp.sv]
// Morton order comparator: less_o is high when point a must come strictly
// before point b. Quotients by 2^level truncate toward zero; bit 0 is skipped.
module mops_cmp #(
  parameter int unsigned Dims = 3,
  parameter int unsigned Cw   = 16
) (
  input  logic [Dims*Cw-1:0] a_i,
  input  logic [Dims*Cw-1:0] b_i,
  output logic               less_o
);

  function automatic logic signed [Cw:0] quo(logic signed [Cw-1:0] x, int unsigned sh);
    logic [Cw:0] mag;
    logic [Cw:0] qm;
    mag = x[Cw-1] ? ((Cw+1)'(0) - {x[Cw-1], x}) : {1'b0, x};
    qm  = mag >> sh;
    return x[Cw-1] ? $signed((Cw+1)'(0) - qm) : $signed(qm);
  endfunction

  // Lower levels and dimensions are visited first, so the most significant
  // difference is the one left standing.
  always_comb begin
    logic signed [Cw:0] qa;
    logic signed [Cw:0] qb;
    less_o = 1'b0;
    for (int unsigned l = 1; l < Cw; l++) begin
      for (int unsigned d = 0; d < Dims; d++) begin
        qa = quo($signed(a_i[d*Cw +: Cw]), l);
        qb = quo($signed(b_i[d*Cw +: Cw]), l);
        if (qa != qb) begin
          less_o = (qa < qb);
        end
      end
    end
  end

endmodule

[src/morton_order_point_sorter_core.sv]
// A transaction without last stores its point, and busy stays low.
// A transaction with last starts a sort over the n stored points; each result
// takes a full scan of the store, and no new point is taken until the last is out.
// The pace is set by the single Morton comparator and the one read port
// of the point memory, which together visit every stored point per result.
// Reset clears the control state only; the point memory is not cleared.
module morton_order_point_sorter_core #(
  parameter int unsigned MAX_BOXES  = mops_pkg::MaxBoxesDef,
  parameter int unsigned DIMS       = mops_pkg::DimsDef,
  parameter int unsigned COORD_BITS = mops_pkg::CoordBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [mops_pkg::InBits-1:0]  coord_0_i,
  input  logic signed [mops_pkg::InBits-1:0]  coord_1_i,
  input  logic signed [mops_pkg::InBits-1:0]  coord_2_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  output logic signed [mops_pkg::InBits-1:0]  out_coord_0_o,
  output logic signed [mops_pkg::InBits-1:0]  out_coord_1_o,
  output logic signed [mops_pkg::InBits-1:0]  out_coord_2_o,
  output logic        [mops_pkg::IdxBits-1:0] source_index_o,
  output logic                                dropped_o,
  output logic                                last_out_o
);

  // Only the low bits of each coordinate that the configured width allows
  // are kept; they are sign extended again on the way out.
  localparam int unsigned Cw   = (COORD_BITS < mops_pkg::InBits) ? COORD_BITS
                                                                 : mops_pkg::InBits;
  localparam int unsigned Aw   = $clog2(MAX_BOXES);
  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);
  localparam int unsigned Pw   = DIMS * Cw;

  mops_pkg::state_e state_q, state_d;

  logic [CntW-1:0]      count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic [CntW-1:0]      sc_q, sc_d;
  logic [CntW-1:0]      pos_q, pos_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [Aw-1:0]        rd_tag_q, rd_tag_d;
  logic                 have_q, have_d;
  logic [MAX_BOXES-1:0] emitted_q, emitted_d;
  logic [Pw-1:0]        best_pt_q, best_pt_d;
  logic [Aw-1:0]        best_idx_q, best_idx_d;

  logic                 accept;
  logic                 room;
  logic                 ram_we;
  logic                 ram_re;
  logic [Pw-1:0]        ram_wdata;
  logic [Pw-1:0]        ram_rdata;
  logic                 less;
  logic                 take;
  logic                 final_res;

  logic [2:0][mops_pkg::InBits-1:0] coord_in;
  logic [2:0][mops_pkg::InBits-1:0] coord_out;

  assign busy   = (state_q != mops_pkg::StIdle);
  assign accept = start && !busy;
  assign room   = (count_q < CntW'(MAX_BOXES));

  // A point is written at the next free entry; its arrival position is the
  // entry's address, so no separate index store is needed.
  assign coord_in = {coord_2_i, coord_1_i, coord_0_i};

  always_comb begin
    ram_wdata = '0;
    for (int unsigned d = 0; d < DIMS; d++) begin
      ram_wdata[d*Cw +: Cw] = coord_in[d][Cw-1:0];
    end
  end

  assign ram_we = accept && room;
  assign ram_re = (state_q == mops_pkg::StScan) && (sc_q < count_q);

  mops_ram #(
    .Width (Pw),
    .Depth (MAX_BOXES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[Aw-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (sc_q[Aw-1:0]),
    .rdata_o (ram_rdata)
  );

  mops_cmp #(
    .Dims (DIMS),
    .Cw   (Cw)
  ) u_cmp (
    .a_i    (ram_rdata),
    .b_i    (best_pt_q),
    .less_o (less)
  );

  // A scan walks the whole store in arrival order and keeps the smallest
  // point not yet sent. Only a strictly smaller point replaces the one held,
  // so among equal points the earliest arrival wins, which keeps the sort
  // stable.
  assign take      = rd_vld_q && !emitted_q[rd_tag_q] && (!have_q || less);
  assign final_res = (CntW'(pos_q + 1'b1) == count_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    sc_d       = sc_q;
    pos_d      = pos_q;
    rd_vld_d   = 1'b0;
    rd_tag_d   = rd_tag_q;
    have_d     = have_q;
    emitted_d  = emitted_q;
    best_pt_d  = best_pt_q;
    best_idx_d = best_idx_q;

    if (take) begin
      have_d     = 1'b1;
      best_pt_d  = ram_rdata;
      best_idx_d = rd_tag_q;
    end

    unique case (state_q)
      mops_pkg::StIdle: begin
        if (accept) begin
          if (room) begin
            count_d = CntW'(count_q + 1'b1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            state_d   = mops_pkg::StScan;
            sc_d      = '0;
            pos_d     = '0;
            have_d    = 1'b0;
            emitted_d = '0;
          end
        end
      end
      mops_pkg::StScan: begin
        rd_vld_d = ram_re;
        rd_tag_d = sc_q[Aw-1:0];
        if (sc_q == count_q) begin
          state_d = mops_pkg::StEmit;
        end else begin
          sc_d = CntW'(sc_q + 1'b1);
        end
      end
      mops_pkg::StEmit: begin
        emitted_d[best_idx_q] = 1'b1;
        if (final_res) begin
          state_d = mops_pkg::StIdle;
          count_d = '0;
          ovf_d   = 1'b0;
        end else begin
          state_d = mops_pkg::StScan;
          sc_d    = '0;
          pos_d   = CntW'(pos_q + 1'b1);
          have_d  = 1'b0;
        end
      end
      default: begin
        state_d = mops_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mops_pkg::StIdle;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      sc_q      <= '0;
      pos_q     <= '0;
      rd_vld_q  <= 1'b0;
      have_q    <= 1'b0;
      emitted_q <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      sc_q      <= sc_d;
      pos_q     <= pos_d;
      rd_vld_q  <= rd_vld_d;
      have_q    <= have_d;
      emitted_q <= emitted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tag_q   <= rd_tag_d;
    best_pt_q  <= best_pt_d;
    best_idx_q <= best_idx_d;
  end

  // The held point is the result during the single emit cycle. Dimensions
  // beyond the configured count read as zero.
  always_comb begin
    logic signed [Cw-1:0] c;
    coord_out = '0;
    for (int unsigned d = 0; d < DIMS; d++) begin
      c            = $signed(best_pt_q[d*Cw +: Cw]);
      coord_out[d] = mops_pkg::InBits'(c);
    end
  end

  assign out_valid_o    = (state_q == mops_pkg::StEmit);
  assign out_coord_0_o  = $signed(coord_out[0]);
  assign out_coord_1_o  = $signed(coord_out[1]);
  assign out_coord_2_o  = $signed(coord_out[2]);
  assign source_index_o = mops_pkg::IdxBits'(best_idx_q);
  assign dropped_o      = ovf_q;
  assign last_out_o     = out_valid_o && final_res;

endmodule

[src/mops_chk.sv]
`include "morton_order_point_sorter_core_defines.svh"

module mops_chk #(
  parameter int unsigned MaxBoxes = mops_pkg::MaxBoxesDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         last_i,
  input logic                         out_valid_o,
  input logic [mops_pkg::IdxBits-1:0] source_index_o,
  input logic                         last_out_o
);

  `MOPS_NEVER(a_res_when_idle, out_valid_o && !busy, "result shown while not busy")
  `MOPS_ASSERT(a_last_starts, start && !busy && last_i |=> busy, "last did not start sort")
  `MOPS_ASSERT(a_mid_stays_idle, start && !busy && !last_i |=> !busy, "busy after plain point")
  `MOPS_ASSERT(a_run_ends, out_valid_o && last_out_o |=> !busy && !out_valid_o, "run did not end")
  `MOPS_ASSERT(a_index_range, out_valid_o |-> source_index_o < MaxBoxes, "index beyond store")

endmodule

bind morton_order_point_sorter_core mops_chk #(.MaxBoxes(MAX_BOXES)) u_chk (.*);
